### hw/rtl/nid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC IR edge decoder package
// Shared types, register indexes, reset values, status codes and the timing
// window check used by the decoder modules.
// ----------------------------------------------------------------------------
package nid_pkg;

	localparam int EDGE_STORE_DEPTH = 128;
	localparam int FRAME_BITS       = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_LEADER_PULSE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEADER_SPACE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_SPACE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_PERIOD   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_PERIOD  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SLACK        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 3'd6;

	localparam logic [CFG_DATA_W-1:0] RST_LEADER_PULSE = 16'd9000;
	localparam logic [CFG_DATA_W-1:0] RST_LEADER_SPACE = 16'd4500;
	localparam logic [CFG_DATA_W-1:0] RST_REPEAT_SPACE = 16'd2250;
	localparam logic [CFG_DATA_W-1:0] RST_ONE_PERIOD   = 16'd2250;
	localparam logic [CFG_DATA_W-1:0] RST_ZERO_PERIOD  = 16'd1125;
	localparam logic [CFG_DATA_W-1:0] RST_SLACK        = 16'd300;
	localparam logic [CFG_DATA_W-1:0] RST_IDLE_TIMEOUT = 16'd10000;

	// Result status codes.
	localparam logic [2:0] ST_NOTHING    = 3'd0;
	localparam logic [2:0] ST_TOO_FEW    = 3'd1;
	localparam logic [2:0] ST_BAD_LEADER = 3'd2;
	localparam logic [2:0] ST_BAD_BIT    = 3'd3;
	localparam logic [2:0] ST_REPEAT     = 3'd4;
	localparam logic [2:0] ST_FRAME      = 3'd5;

	localparam logic [7:0] BYTE_MASK       = 8'hFF;
	localparam logic [1:0] LEADER_FLAGS_OK = 2'd3;

	typedef struct packed {
		logic        req_type;
		logic [1:0]  edge_kind;
		logic [31:0] time_us;
	} item_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] leader_pulse_us;
		logic [CFG_DATA_W-1:0] leader_space_us;
		logic [CFG_DATA_W-1:0] repeat_space_us;
		logic [CFG_DATA_W-1:0] one_period_us;
		logic [CFG_DATA_W-1:0] zero_period_us;
		logic [CFG_DATA_W-1:0] slack_us;
		logic [CFG_DATA_W-1:0] idle_timeout_us;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] raw_word;
		logic [7:0]  command_byte;
		logic        command_ok;
	} result_t;

	// True when the measured span lies within slack of the target.
	function automatic logic in_window(input logic [31:0] span,
		input logic [CFG_DATA_W-1:0] target, input logic [CFG_DATA_W-1:0] slack);
		logic [31:0] tgt;
		logic [31:0] diff;
		tgt  = {16'd0, target};
		diff = (span >= tgt) ? span - tgt : tgt - span;
		return diff <= {16'd0, slack};
	endfunction

endpackage

### hw/rtl/nid_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC IR decoder configuration registers
// Write-only timing registers, loaded from the plain write port.
// ----------------------------------------------------------------------------
module nid_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [nid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nid_pkg::CFG_DATA_W-1:0] cfg_data,
	output nid_pkg::cfg_t                  cfg
);

	nid_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.leader_pulse_us <= nid_pkg::RST_LEADER_PULSE;
			cfg_q.leader_space_us <= nid_pkg::RST_LEADER_SPACE;
			cfg_q.repeat_space_us <= nid_pkg::RST_REPEAT_SPACE;
			cfg_q.one_period_us   <= nid_pkg::RST_ONE_PERIOD;
			cfg_q.zero_period_us  <= nid_pkg::RST_ZERO_PERIOD;
			cfg_q.slack_us        <= nid_pkg::RST_SLACK;
			cfg_q.idle_timeout_us <= nid_pkg::RST_IDLE_TIMEOUT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nid_pkg::REG_LEADER_PULSE: cfg_q.leader_pulse_us <= cfg_data;
				nid_pkg::REG_LEADER_SPACE: cfg_q.leader_space_us <= cfg_data;
				nid_pkg::REG_REPEAT_SPACE: cfg_q.repeat_space_us <= cfg_data;
				nid_pkg::REG_ONE_PERIOD:   cfg_q.one_period_us   <= cfg_data;
				nid_pkg::REG_ZERO_PERIOD:  cfg_q.zero_period_us  <= cfg_data;
				nid_pkg::REG_SLACK:        cfg_q.slack_us        <= cfg_data;
				nid_pkg::REG_IDLE_TIMEOUT: cfg_q.idle_timeout_us <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hw/rtl/nid_frame_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC IR frame tracker
// Classifies each edge as it arrives (leader pulse, leader space, data bits)
// and forms the decode result when an idle check finds the line quiet.
// ----------------------------------------------------------------------------
module nid_frame_tracker #(
	parameter int EDGE_STORE_DEPTH = nid_pkg::EDGE_STORE_DEPTH,
	parameter int FRAME_BITS       = nid_pkg::FRAME_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  nid_pkg::cfg_t    cfg,
	input  nid_pkg::item_t   item,
	input  logic             fire,
	output nid_pkg::result_t result
);

	localparam int CW = $clog2(EDGE_STORE_DEPTH + 1);
	localparam int BW = $clog2(FRAME_BITS + 1);

	typedef enum logic [1:0] {
		CLS_PENDING,
		CLS_REPEAT,
		CLS_FRAME,
		CLS_BAD
	} leader_class_t;

	logic [CW-1:0]         edge_count_q;
	logic [31:0]           first_edge_time_q;
	logic [31:0]           second_edge_time_q;
	logic [1:0]            leader_flags_q;
	leader_class_t         leader_class_q;
	logic [31:0]           last_fall_time_q;
	logic [31:0]           last_edge_time_q;
	logic [FRAME_BITS-1:0] shift_word_q;
	logic [BW-1:0]         bits_taken_q;
	logic                  bit_error_q;
	logic [31:0]           previous_word_q;

	logic        is_fall;
	logic        is_rise;
	logic        store_full;
	logic        at_space;
	logic [31:0] pulse;
	logic [31:0] span;
	logic        pulse_ok;
	logic        win_a;
	logic        win_b;
	logic        decode;
	logic [2:0]  status;
	logic [31:0] raw;

	assign is_fall    = item.edge_kind[0];
	assign is_rise    = item.edge_kind[1];
	assign store_full = edge_count_q >= CW'(EDGE_STORE_DEPTH);
	assign at_space   = edge_count_q == CW'(2);

	// The edge that ends the leader space measures it and later edges measure bit
	// periods, so one subtractor and two window checks serve both.
	assign pulse    = second_edge_time_q - first_edge_time_q;
	assign span     = item.time_us - (at_space ? second_edge_time_q : last_fall_time_q);
	assign pulse_ok = nid_pkg::in_window(pulse, cfg.leader_pulse_us, cfg.slack_us);
	assign win_a    = nid_pkg::in_window(span,
		at_space ? cfg.repeat_space_us : cfg.one_period_us, cfg.slack_us);
	assign win_b    = nid_pkg::in_window(span,
		at_space ? cfg.leader_space_us : cfg.zero_period_us, cfg.slack_us);

	assign decode = (edge_count_q != '0) &&
		((item.time_us - last_edge_time_q) > {16'd0, cfg.idle_timeout_us});

	always_comb begin
		status = nid_pkg::ST_NOTHING;
		raw    = '0;
		if (decode) begin
			if (edge_count_q < CW'(3)) begin
				status = nid_pkg::ST_TOO_FEW;
			end else if (leader_class_q == CLS_REPEAT) begin
				status = nid_pkg::ST_REPEAT;
				raw    = previous_word_q;
			end else if (leader_class_q != CLS_FRAME) begin
				status = nid_pkg::ST_BAD_LEADER;
			end else if (bit_error_q) begin
				status = nid_pkg::ST_BAD_BIT;
			end else begin
				status = nid_pkg::ST_FRAME;
				raw    = 32'(shift_word_q);
			end
		end
	end

	assign result.status       = status;
	assign result.raw_word     = raw;
	assign result.command_byte = raw[15:8];
	assign result.command_ok   = (raw != '0) &&
		((raw[15:8] ^ raw[7:0]) == nid_pkg::BYTE_MASK) &&
		((raw[31:24] ^ raw[23:16]) == nid_pkg::BYTE_MASK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q       <= '0;
			first_edge_time_q  <= '0;
			second_edge_time_q <= '0;
			leader_flags_q     <= '0;
			leader_class_q     <= CLS_PENDING;
			last_fall_time_q   <= '0;
			last_edge_time_q   <= '0;
			shift_word_q       <= '0;
			bits_taken_q       <= '0;
			bit_error_q        <= 1'b0;
			previous_word_q    <= '0;
		end else if (fire) begin
			if (item.req_type) begin
				if (decode) begin
					edge_count_q <= '0;
					if (status == nid_pkg::ST_FRAME) begin
						previous_word_q <= raw;
					end
				end
			end else if (store_full) begin
				// A full store drops the edge and restarts the frame.
				edge_count_q <= '0;
			end else begin
				edge_count_q     <= edge_count_q + CW'(1);
				last_edge_time_q <= item.time_us;
				if (edge_count_q == '0) begin
					first_edge_time_q <= item.time_us;
					leader_flags_q    <= {1'b0, is_fall};
					leader_class_q    <= CLS_PENDING;
					shift_word_q      <= '0;
					bits_taken_q      <= '0;
					bit_error_q       <= 1'b0;
				end else if (edge_count_q == CW'(1)) begin
					second_edge_time_q <= item.time_us;
					leader_flags_q     <= leader_flags_q | {is_rise, 1'b0};
				end else if (at_space) begin
					last_fall_time_q <= item.time_us;
					if (leader_flags_q != nid_pkg::LEADER_FLAGS_OK || !is_fall || !pulse_ok) begin
						leader_class_q <= CLS_BAD;
					end else if (win_a) begin
						leader_class_q <= CLS_REPEAT;
					end else if (win_b) begin
						leader_class_q <= CLS_FRAME;
					end else begin
						leader_class_q <= CLS_BAD;
					end
				end else if (!bit_error_q && bits_taken_q < BW'(FRAME_BITS) && !is_rise) begin
					last_fall_time_q <= item.time_us;
					if (win_a) begin
						shift_word_q <= {shift_word_q[FRAME_BITS-2:0], 1'b1};
						bits_taken_q <= bits_taken_q + BW'(1);
					end else if (win_b) begin
						shift_word_q <= {shift_word_q[FRAME_BITS-2:0], 1'b0};
						bits_taken_q <= bits_taken_q + BW'(1);
					end else begin
						bit_error_q <= 1'b1;
					end
				end
			end
		end
	end

endmodule

### hw/rtl/nid_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC IR decoder output register
// Holds one result for the downstream side and frees itself in the cycle
// that the result is taken.
// ----------------------------------------------------------------------------
module nid_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  nid_pkg::result_t load_data,
	input  logic             m_tready,
	output logic             m_tvalid,
	output nid_pkg::result_t data,
	output logic             room
);

	logic             valid_q;
	nid_pkg::result_t data_q;

	assign room     = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign data     = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

endmodule

### hw/rtl/nec_ir_edge_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC IR edge decoder
// Decodes NEC infrared frames from a stream of timestamped edge events and
// reports one result for every idle check.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle, edges and idle checks
// alike. An item is held in the input register while its edge is
// classified against the timing registers, and a check's result is loaded
// into the output register as the check leaves the input register, so a
// result passes through both registers before it is presented.
// Edges produce no result. The only thing that slows the input is a stalled
// output: a check waits in the input register while a result that has not
// been taken still fills the output register.
module nec_ir_edge_decoder_unit #(
	parameter int EDGE_STORE_DEPTH = nid_pkg::EDGE_STORE_DEPTH,
	parameter int FRAME_BITS       = nid_pkg::FRAME_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [nid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nid_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [31:0]                    s_tdata,   // time_us
	input  logic [2:0]                     s_tuser,   // req_type, edge_kind
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [47:0]                    m_tdata,   // raw_word, command_byte, command_ok
	output logic [2:0]                     m_tuser    // status
);

	nid_pkg::cfg_t    cfg;
	nid_pkg::item_t   item_s1;
	logic             valid_s1;
	logic             fire;
	logic             room;
	nid_pkg::result_t result;
	nid_pkg::result_t out_data;

	nid_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// An edge always leaves the input register; a check needs output room.
	assign fire     = valid_s1 && (!item_s1.req_type || room);
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.req_type  <= s_tuser[0];
			item_s1.edge_kind <= s_tuser[2:1];
			item_s1.time_us   <= s_tdata;
		end
	end

	nid_frame_tracker #(
		.EDGE_STORE_DEPTH (EDGE_STORE_DEPTH),
		.FRAME_BITS       (FRAME_BITS)
	) u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.fire   (fire),
		.result (result)
	);

	nid_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && item_s1.req_type),
		.load_data (result),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.data      (out_data),
		.room      (room)
	);

	assign m_tdata = {7'd0, out_data.command_ok, out_data.command_byte, out_data.raw_word};
	assign m_tuser = out_data.status;

	// A check leaving the input register always shows up at the output.
	a_check_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.req_type |=> m_tvalid)
	else $error("idle check did not produce a result");

	// A decoded frame never carries bits beyond the frame length.
	a_frame_width: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == nid_pkg::ST_FRAME |->
		(m_tdata[31:0] >> FRAME_BITS) == 32'd0)
	else $error("frame word wider than the frame length");

	// Results without a word report all payload fields as zero.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == nid_pkg::ST_NOTHING || m_tuser == nid_pkg::ST_TOO_FEW ||
		m_tuser == nid_pkg::ST_BAD_LEADER || m_tuser == nid_pkg::ST_BAD_BIT) |->
		m_tdata[40:0] == 41'd0)
	else $error("nonzero payload on a result without a word");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC IR edge decoder testbench
// Streams edge events and idle checks into the decoder and compares every
// result against an in-bench prediction of the decoder. The stimulus is
// mostly well-formed NEC frames and repeats with random content and timing
// jitter, mixed with broken leaders, bad bits, store overflows and noise.
// It runs through several register settings and phases of random idling
// on both streams.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CLK_PERIOD        = 12;
	localparam int NUM_REGS          = 7;
	localparam int ITEMS_PER_SETTING = 210;

	localparam logic       REQ_EDGE  = 1'b0;
	localparam logic       REQ_CHECK = 1'b1;
	localparam logic [1:0] KIND_NONE = 2'b00;
	localparam logic [1:0] KIND_FALL = 2'b01;
	localparam logic [1:0] KIND_RISE = 2'b10;
	localparam logic [1:0] KIND_BOTH = 2'b11;

	typedef enum logic [1:0] {LDR_PENDING, LDR_REPEAT, LDR_FRAME, LDR_BAD} ldr_class_t;
	typedef enum {BURST_FRAME, BURST_REPEAT, BURST_BAD_PULSE, BURST_BAD_SPACE,
		BURST_BAD_KIND, BURST_BAD_BIT} burst_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [nid_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [nid_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [31:0]                    s_tdata = '0;
	logic [2:0]                     s_tuser = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [47:0]                    m_tdata;
	logic [2:0]                     m_tuser;

	nec_ir_edge_decoder_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	nid_pkg::item_t   edge_q[$];
	nid_pkg::item_t   drv_item;
	nid_pkg::result_t decode_q[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int n_items        = 0;
	int n_checks       = 0;
	int n_results      = 0;
	int mismatches     = 0;

	logic [31:0] now_us;

	// Predicted decoder state and register copy.
	logic [nid_pkg::CFG_DATA_W-1:0] reg_val [NUM_REGS];
	int                             edge_cnt = 0;
	logic [31:0]                    first_edge_us = '0;
	logic [31:0]                    second_edge_us = '0;
	logic [31:0]                    last_fall_us = '0;
	logic [31:0]                    last_edge_us = '0;
	logic [31:0]                    shift_word = '0;
	logic [31:0]                    prev_word = '0;
	logic [1:0]                     leader_seen = '0;
	ldr_class_t                     ldr_class = LDR_PENDING;
	int                             bits_in = 0;
	bit                             bit_err = 1'b0;

	initial begin
		reg_val[nid_pkg::REG_LEADER_PULSE] = nid_pkg::RST_LEADER_PULSE;
		reg_val[nid_pkg::REG_LEADER_SPACE] = nid_pkg::RST_LEADER_SPACE;
		reg_val[nid_pkg::REG_REPEAT_SPACE] = nid_pkg::RST_REPEAT_SPACE;
		reg_val[nid_pkg::REG_ONE_PERIOD]   = nid_pkg::RST_ONE_PERIOD;
		reg_val[nid_pkg::REG_ZERO_PERIOD]  = nid_pkg::RST_ZERO_PERIOD;
		reg_val[nid_pkg::REG_SLACK]        = nid_pkg::RST_SLACK;
		reg_val[nid_pkg::REG_IDLE_TIMEOUT] = nid_pkg::RST_IDLE_TIMEOUT;
	end

	function automatic bit within_slack(input logic [31:0] span, input logic [15:0] target);
		logic [31:0] tgt;
		logic [31:0] gap;
		tgt = {16'd0, target};
		gap = (span >= tgt) ? span - tgt : tgt - span;
		return gap <= {16'd0, reg_val[nid_pkg::REG_SLACK]};
	endfunction

	// Advances the predicted state by one accepted transaction.
	function automatic void model_item(input nid_pkg::item_t it);
		logic [31:0]      pulse;
		logic [31:0]      space;
		logic [31:0]      delta;
		logic [31:0]      raw;
		nid_pkg::result_t res;
		int               idx;
		if (it.req_type == REQ_EDGE) begin
			if (edge_cnt >= nid_pkg::EDGE_STORE_DEPTH) begin
				edge_cnt = 0;
			end else begin
				idx = edge_cnt;
				edge_cnt++;
				last_edge_us = it.time_us;
				case (idx)
					0: begin
						first_edge_us = it.time_us;
						leader_seen   = {1'b0, it.edge_kind[0]};
						ldr_class     = LDR_PENDING;
						shift_word    = '0;
						bits_in       = 0;
						bit_err       = 1'b0;
					end
					1: begin
						second_edge_us = it.time_us;
						if (it.edge_kind[1])
							leader_seen[1] = 1'b1;
					end
					2: begin
						pulse        = second_edge_us - first_edge_us;
						space        = it.time_us - second_edge_us;
						last_fall_us = it.time_us;
						if (leader_seen != nid_pkg::LEADER_FLAGS_OK || !it.edge_kind[0] ||
							!within_slack(pulse, reg_val[nid_pkg::REG_LEADER_PULSE]))
							ldr_class = LDR_BAD;
						else if (within_slack(space, reg_val[nid_pkg::REG_REPEAT_SPACE]))
							ldr_class = LDR_REPEAT;
						else if (within_slack(space, reg_val[nid_pkg::REG_LEADER_SPACE]))
							ldr_class = LDR_FRAME;
						else
							ldr_class = LDR_BAD;
					end
					default: begin
						// Rising edges, bits past the frame and bits after an error are skipped.
						if (!bit_err && bits_in < nid_pkg::FRAME_BITS && !it.edge_kind[1]) begin
							delta        = it.time_us - last_fall_us;
							last_fall_us = it.time_us;
							if (within_slack(delta, reg_val[nid_pkg::REG_ONE_PERIOD])) begin
								shift_word = {shift_word[30:0], 1'b1};
								bits_in++;
							end else if (within_slack(delta,
								reg_val[nid_pkg::REG_ZERO_PERIOD])) begin
								shift_word = {shift_word[30:0], 1'b0};
								bits_in++;
							end else begin
								bit_err = 1'b1;
							end
						end
					end
				endcase
			end
		end else begin
			res        = '0;
			res.status = nid_pkg::ST_NOTHING;
			raw        = '0;
			if (edge_cnt > 0 && (it.time_us - last_edge_us) >
				{16'd0, reg_val[nid_pkg::REG_IDLE_TIMEOUT]}) begin
				if (edge_cnt < 3) begin
					res.status = nid_pkg::ST_TOO_FEW;
				end else if (ldr_class == LDR_REPEAT) begin
					res.status = nid_pkg::ST_REPEAT;
					raw        = prev_word;
				end else if (ldr_class != LDR_FRAME) begin
					res.status = nid_pkg::ST_BAD_LEADER;
				end else if (bit_err) begin
					res.status = nid_pkg::ST_BAD_BIT;
				end else begin
					res.status = nid_pkg::ST_FRAME;
					raw        = shift_word;
					prev_word  = shift_word;
				end
				edge_cnt = 0;
			end
			res.raw_word     = raw;
			res.command_byte = raw[15:8];
			res.command_ok   = (raw != '0) &&
				((raw[15:8] ^ raw[7:0]) == nid_pkg::BYTE_MASK) &&
				((raw[31:24] ^ raw[23:16]) == nid_pkg::BYTE_MASK);
			decode_q.push_back(res);
		end
	endfunction

	// Input driver: presents queued items and feeds each accepted transaction to the predictor.
	always @(posedge clk) begin : feed
		nid_pkg::item_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				model_item(drv_item);
			if (!s_tvalid || s_tready) begin
				if (edge_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = edge_q.pop_front();
					drv_item <= nxt;
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.time_us;
					s_tuser  <= {nxt.edge_kind, nxt.req_type};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want) begin
			if (mismatches < 10)
				$display("mismatch in %s of result %0d: expected 0x%0h, got 0x%0h",
					name, n_results, want, got);
			mismatches++;
		end
	endtask

	// Output monitor with random back-pressure.
	always @(posedge clk) begin : watch
		nid_pkg::result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (decode_q.size() == 0) begin
					if (mismatches < 10)
						$display("result %0d arrived with no transaction expected", n_results);
					mismatches++;
				end else begin
					want = decode_q.pop_front();
					check_field("status", m_tuser, want.status);
					check_field("raw_word", m_tdata[31:0], want.raw_word);
					check_field("command_byte", m_tdata[39:32], want.command_byte);
					check_field("command_ok", m_tdata[40], want.command_ok);
				end
				n_results++;
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic add_item(input logic req, input logic [1:0] kind, input logic [31:0] t);
		nid_pkg::item_t it;
		it.req_type  = req;
		it.edge_kind = kind;
		it.time_us   = t;
		edge_q.push_back(it);
		n_items++;
		if (req == REQ_CHECK)
			n_checks++;
	endtask

	// A span close to the target, within or on the slack window, just outside it when asked to miss.
	function automatic logic [31:0] span_near(input logic [15:0] target, input bit miss);
		int s;
		int off;
		s = int'(reg_val[nid_pkg::REG_SLACK]);
		if (miss) begin
			off = s + 1 + int'($urandom_range(0, 40));
			if ($urandom_range(1))
				off = -off;
		end else begin
			case ($urandom_range(3))
				0:       off = s;
				1:       off = -s;
				default: off = int'($urandom_range(0, 2 * s)) - s;
			endcase
		end
		return 32'(int'(target) + off);
	endfunction

	task automatic add_burst(input burst_t shape, input int nbits, input logic [31:0] word);
		logic [31:0] t;
		logic [31:0] span;
		int          wrong;
		int          bad_at;
		wrong  = (shape == BURST_BAD_KIND) ? int'($urandom_range(2)) : -1;
		bad_at = (shape == BURST_BAD_BIT) ? int'($urandom_range(0, nbits - 1)) : -1;
		t = now_us + 32'($urandom_range(1, 3000));
		if (wrong == 0)
			add_item(REQ_EDGE, $urandom_range(1) ? KIND_NONE : KIND_RISE, t);
		else
			add_item(REQ_EDGE, $urandom_range(1) ? KIND_FALL : KIND_BOTH, t);
		t = t + span_near(reg_val[nid_pkg::REG_LEADER_PULSE], shape == BURST_BAD_PULSE);
		if (wrong == 1)
			add_item(REQ_EDGE, $urandom_range(1) ? KIND_NONE : KIND_FALL, t);
		else
			add_item(REQ_EDGE, $urandom_range(1) ? KIND_RISE : KIND_BOTH, t);
		if (shape == BURST_REPEAT)
			t = t + span_near(reg_val[nid_pkg::REG_REPEAT_SPACE], 1'b0);
		else
			t = t + span_near(reg_val[nid_pkg::REG_LEADER_SPACE], shape == BURST_BAD_SPACE);
		if (wrong == 2)
			add_item(REQ_EDGE, $urandom_range(1) ? KIND_NONE : KIND_RISE, t);
		else
			add_item(REQ_EDGE, $urandom_range(1) ? KIND_FALL : KIND_BOTH, t);
		for (int i = 0; i < nbits; i++) begin
			if (word[31 - (i % 32)])
				span = span_near(reg_val[nid_pkg::REG_ONE_PERIOD], i == bad_at);
			else
				span = span_near(reg_val[nid_pkg::REG_ZERO_PERIOD], i == bad_at);
			add_item(REQ_EDGE, $urandom_range(1) ? KIND_RISE : KIND_BOTH, t + span / 2);
			t = t + span;
			add_item(REQ_EDGE, $urandom_range(3) != 0 ? KIND_FALL : KIND_NONE, t);
		end
		now_us = t;
	endtask

	// Enough edges to overflow the edge store, with random kinds.
	task automatic add_overflow();
		int n;
		n = nid_pkg::EDGE_STORE_DEPTH + 1 + int'($urandom_range(0, 4));
		for (int i = 0; i < n; i++) begin
			now_us = now_us + 32'($urandom_range(0, 900));
			add_item(REQ_EDGE, 2'($urandom_range(3)), now_us);
		end
	endtask

	// Sometimes a check before the line is idle, then one after the timeout.
	task automatic add_checks();
		if ($urandom_range(4) == 0)
			add_item(REQ_CHECK, 2'($urandom_range(3)),
				now_us + 32'($urandom_range(0, reg_val[nid_pkg::REG_IDLE_TIMEOUT])));
		now_us = now_us + {16'd0, reg_val[nid_pkg::REG_IDLE_TIMEOUT]} + 1 +
			32'($urandom_range(0, 500));
		add_item(REQ_CHECK, 2'($urandom_range(3)), now_us);
	endtask

	// Waits until every queued item went in and every predicted result came out.
	task automatic settle();
		while (edge_q.size() != 0 || s_tvalid || decode_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apply_cfg(input int setting);
		logic [nid_pkg::CFG_DATA_W-1:0] new_val [NUM_REGS];
		new_val[nid_pkg::REG_LEADER_PULSE] = nid_pkg::RST_LEADER_PULSE;
		new_val[nid_pkg::REG_LEADER_SPACE] = nid_pkg::RST_LEADER_SPACE;
		new_val[nid_pkg::REG_REPEAT_SPACE] = nid_pkg::RST_REPEAT_SPACE;
		new_val[nid_pkg::REG_ONE_PERIOD]   = nid_pkg::RST_ONE_PERIOD;
		new_val[nid_pkg::REG_ZERO_PERIOD]  = nid_pkg::RST_ZERO_PERIOD;
		new_val[nid_pkg::REG_SLACK]        = nid_pkg::RST_SLACK;
		new_val[nid_pkg::REG_IDLE_TIMEOUT] = nid_pkg::RST_IDLE_TIMEOUT;
		case (setting)
			0: ;
			1: new_val[nid_pkg::REG_SLACK] = '0;
			2, 4: begin
				new_val[nid_pkg::REG_LEADER_PULSE] = 16'($urandom_range(3000, 20000));
				new_val[nid_pkg::REG_LEADER_SPACE] = 16'($urandom_range(2000, 9000));
				new_val[nid_pkg::REG_REPEAT_SPACE] = 16'($urandom_range(1000, 5000));
				new_val[nid_pkg::REG_ONE_PERIOD]   = 16'($urandom_range(500, 4000));
				new_val[nid_pkg::REG_ZERO_PERIOD]  = 16'($urandom_range(300, 3000));
				new_val[nid_pkg::REG_SLACK]        = 16'($urandom_range(0, 600));
				new_val[nid_pkg::REG_IDLE_TIMEOUT] = 16'($urandom);
				// Identical periods: every bit within the window reads as a one.
				if (setting == 4)
					new_val[nid_pkg::REG_ZERO_PERIOD] = new_val[nid_pkg::REG_ONE_PERIOD];
			end
			3: for (int i = 0; i < NUM_REGS; i++) new_val[i] = '0;
			5: for (int i = 0; i < NUM_REGS; i++) new_val[i] = '1;
			6: for (int i = 0; i < NUM_REGS; i++) new_val[i] = 16'($urandom);
			default: begin
				// Wide slack makes the one and zero windows overlap.
				new_val[nid_pkg::REG_SLACK]        = 16'd1000;
				new_val[nid_pkg::REG_IDLE_TIMEOUT] = '1;
			end
		endcase
		for (int i = 0; i < NUM_REGS; i++) begin
			@(posedge clk);
			cfg_we     <= 1'b1;
			cfg_index  <= i[nid_pkg::CFG_IDX_W-1:0];
			cfg_data   <= new_val[i];
			reg_val[i] = new_val[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin : stimulus
		int          base_items;
		int          base_checks;
		int          pick;
		int          nbits;
		logic [31:0] word;
		logic [7:0]  addr;
		logic [7:0]  cmd;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset register values, starting at the time wrap.
		add_item(REQ_CHECK, KIND_BOTH, 32'h0000_0000);
		add_item(REQ_EDGE, KIND_FALL, 32'hFFFF_FFFF);
		now_us = 32'hFFFF_FFFF + {16'd0, reg_val[nid_pkg::REG_IDLE_TIMEOUT]} + 1;
		add_item(REQ_CHECK, KIND_NONE, now_us);
		add_burst(BURST_REPEAT, 0, '0);
		add_item(REQ_CHECK, KIND_RISE, now_us);
		add_item(REQ_CHECK, KIND_FALL, now_us + {16'd0, reg_val[nid_pkg::REG_IDLE_TIMEOUT]});
		now_us = now_us + {16'd0, reg_val[nid_pkg::REG_IDLE_TIMEOUT]} + 1;
		add_item(REQ_CHECK, KIND_BOTH, now_us);
		add_burst(BURST_FRAME, 4, 32'hA000_0000);
		add_checks();
		add_burst(BURST_BAD_PULSE, 0, '0);
		add_checks();

		for (int setting = 0; setting < 8; setting++) begin
			settle();
			apply_cfg(setting);
			case (setting / 2)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
				default: begin send_idle_pct = 21; recv_stall_pct = 21; end
			endcase
			base_items  = n_items;
			base_checks = n_checks;
			if (setting == 0) begin
				add_overflow();
				add_checks();
			end
			while (n_items - base_items < ITEMS_PER_SETTING || n_checks - base_checks < 8) begin
				pick  = $urandom_range(99);
				nbits = ($urandom_range(4) < 2) ? nid_pkg::FRAME_BITS :
					int'($urandom_range(0, 33));
				addr  = 8'($urandom);
				cmd   = 8'($urandom);
				word  = $urandom_range(1) ? {addr, ~addr, cmd, ~cmd} : $urandom;
				if (pick < 45)
					add_burst(BURST_FRAME, nbits, word);
				else if (pick < 60)
					add_burst(BURST_REPEAT, $urandom_range(3) == 0 ? $urandom_range(1, 3) : 0, word);
				else if (pick < 68)
					add_burst(BURST_BAD_PULSE, $urandom_range(0, 4), word);
				else if (pick < 76)
					add_burst(BURST_BAD_SPACE, $urandom_range(0, 4), word);
				else if (pick < 82)
					add_burst(BURST_BAD_KIND, $urandom_range(0, 4), word);
				else if (pick < 90)
					add_burst(BURST_BAD_BIT, $urandom_range(1, nid_pkg::FRAME_BITS), word);
				else if (pick < 97) begin
					// Loose items that do not form a frame.
					repeat ($urandom_range(1, 6)) begin
						if ($urandom_range(1))
							now_us = now_us + 32'($urandom_range(0, 20000));
						else
							now_us = $urandom;
						add_item(1'($urandom_range(1)), 2'($urandom_range(3)), now_us);
					end
				end else
					add_overflow();
				if (pick < 90 || pick >= 97)
					add_checks();
			end
		end

		settle();
		if (mismatches == 0 && decode_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#(CLK_PERIOD * 200000);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
